>>> design/sf3_pkg.sv
package sf3_pkg;

    localparam int IMAGE_WIDTH  = 128;
    localparam int IMAGE_HEIGHT = 128;

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

    localparam logic [7:0] CENTER_WEIGHT_RST   = 8'sd9;
    localparam logic [7:0] NEIGHBOR_WEIGHT_RST = 8'hFF;

    typedef enum logic [0:0] {
        CFG_CENTER_WEIGHT   = 1'b0,
        CFG_NEIGHBOR_WEIGHT = 1'b1
    } t_cfg_idx;

    // Control travelling from the first stage to the line buffer.
    typedef struct packed {
        logic             adv;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [COL_W-1:0] rd_addr;
    } t_lb_ctrl;

endpackage

>>> design/sf3_linebuf.sv
module sf3_linebuf (
    input  logic                   i_clk,
    input  sf3_pkg::t_lb_ctrl      i_ctrl,
    input  logic [7:0]             i_wr_px,
    output logic [7:0]             o_up_px,
    output logic [7:0]             o_mid_px
);
    import sf3_pkg::*;

    logic [7:0] r_upper  [IMAGE_WIDTH];
    logic [7:0] r_middle [IMAGE_WIDTH];
    logic [7:0] r_up_rd;
    logic [7:0] r_mid_rd;
    logic       w_hit;

    // The word in the first stage is written back at the same edge at which the
    // next word reads; when both touch the same column the fresh data is forwarded.
    assign w_hit = i_ctrl.wr_en && (i_ctrl.wr_addr == i_ctrl.rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            if (i_ctrl.wr_en) begin
                r_upper[i_ctrl.wr_addr]  <= r_mid_rd;
                r_middle[i_ctrl.wr_addr] <= i_wr_px;
            end
            if (w_hit) begin
                r_up_rd  <= r_mid_rd;
                r_mid_rd <= i_wr_px;
            end else begin
                r_up_rd  <= r_upper[i_ctrl.rd_addr];
                r_mid_rd <= r_middle[i_ctrl.rd_addr];
            end
        end
    end

    assign o_up_px  = r_up_rd;
    assign o_mid_px = r_mid_rd;

endmodule

>>> design/sharpen_filter_3x3_top.sv
// 3x3 sharpening filter for a 128 x 128 image of 8-bit pixels in raster order.
// Input words arrive on i_valid/o_ready with i_pixel_in and i_frame_start; a
// set frame_start restarts counting at row 0, column 0 with that pixel.
// Results leave on o_valid/i_ready: o_pixel_out is the low 8 bits of
// centre * centre_weight + neighbour_weight * (sum of eight neighbours) for
// each interior position, and o_last_out marks the last interior pixel.
// Border positions give no result word.
// Two weight registers are written through i_cfg_we/i_cfg_idx/i_cfg_data.
// The block takes one word per clock while the output is not stalled. A word
// passes a line buffer read stage and the arithmetic into the output register,
// where its result is shown; the line buffer memories are read with the
// column of the accepted word, so their data stands beside it in that stage.
// When the receiver holds i_ready low with a result shown, the whole pipe
// stops and o_ready falls; when no result is waiting, input keeps flowing.
// Reset clears the counters, the pipe's valid flags and restores the weights
// to 9 and -1. Line buffer contents are not cleared.
module sharpen_filter_3x3_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_pixel_in,
    input  logic       i_frame_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_pixel_out,
    output logic       o_last_out,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import sf3_pkg::*;

    logic [7:0]       r_center_w;
    logic [7:0]       r_neighbor_w;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    logic             w_adv;
    logic             w_acc;

    logic             r_s1_valid;
    logic [7:0]       r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    logic             r_s1_last;

    logic [7:0]       r_win [3][3];
    logic [7:0]       w_up_px;
    logic [7:0]       w_mid_px;
    t_lb_ctrl         w_lb_ctrl;

    logic [7:0]       w_nsum;
    logic [7:0]       w_total;

    logic             r_out_valid;
    logic [7:0]       r_out_px;
    logic             r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_w   <= CENTER_WEIGHT_RST;
            r_neighbor_w <= NEIGHBOR_WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_WEIGHT:   r_center_w   <= i_cfg_data;
                CFG_NEIGHBOR_WEIGHT: r_neighbor_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipe moves as a whole whenever the output register is free or taken.
    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;

    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;

    always_comb begin
        n_col = w_col + COL_W'(1);
        n_row = w_row;
        if (w_col == COL_LAST) begin
            n_col = '0;
            n_row = (w_row == ROW_LAST) ? '0 : w_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            if (i_valid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_px   <= i_pixel_in;
            r_s1_col  <= w_col;
            r_s1_emit <= (w_row >= ROW_W'(2)) && (w_col >= COL_W'(2));
            r_s1_last <= (w_row == ROW_LAST) && (w_col == COL_LAST);
        end
    end

    assign w_lb_ctrl.adv     = w_adv;
    assign w_lb_ctrl.wr_en   = r_s1_valid;
    assign w_lb_ctrl.wr_addr = r_s1_col;
    assign w_lb_ctrl.rd_addr = w_col;

    sf3_linebuf u_linebuf (
        .i_clk    (i_clk),
        .i_ctrl   (w_lb_ctrl),
        .i_wr_px  (r_s1_px),
        .o_up_px  (w_up_px),
        .o_mid_px (w_mid_px)
    );

    // Only the low eight bits of the result are kept, so the sums and products
    // can be formed modulo 256 and signedness of the weights drops out.
    // The sums see the window as it will stand once the new column is shifted
    // in: the old middle and right columns plus the column from the line buffer.
    always_comb begin
        w_nsum  = r_win[0][1] + r_win[1][1] + r_win[2][1]
                + r_win[0][2] + r_win[2][2]
                + w_up_px + w_mid_px + r_s1_px;
        w_total = r_center_w * r_win[1][2] + r_neighbor_w * w_nsum;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= w_up_px;
            r_win[1][2] <= w_mid_px;
            r_win[2][2] <= r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_px   <= w_total;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_px;
    assign o_last_out  = r_out_last;

endmodule
